FILE: rtl/mga_pkg.sv
`timescale 1ns / 1ps
// Package for the maze grid to adjacency block.
// Holds shared widths, character codes, payload structs, cell ops and FSM states.
package mga_pkg;

    localparam int MAX_ROW_WIDTH = 32;
    localparam int COL_W         = $clog2(MAX_ROW_WIDTH + 1);
    localparam int IDX_W         = $clog2(MAX_ROW_WIDTH);
    localparam int ID_W          = 16;

    localparam logic [ID_W-1:0] ID_MAX   = '1;
    localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);
    localparam logic [ID_W-1:0] ID_NONE  = '0;

    localparam logic [7:0] CH_OPEN    = 8'h2D;
    localparam logic [7:0] CH_WALL    = 8'h23;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    typedef logic [ID_W-1:0] node_id_t;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_input;
    } in_t;

    typedef struct packed {
        node_id_t node_id;
        node_id_t north_id;
        node_id_t east_id;
        node_id_t south_id;
        node_id_t west_id;
        logic     last;
        logic     overflow;
    } out_t;

    // One column of the three row buffers
    typedef struct packed {
        node_id_t above;
        node_id_t middle;
        node_id_t below;
    } col_data_t;

    typedef enum logic [2:0] {
        CELL_IDLE,
        CELL_WRITE,
        CELL_ROTATE,
        CELL_SHIFT,
        CELL_ROT_SHIFT,
        CELL_CLR_BELOW,
        CELL_CLEAR
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        node_id_t wr_data;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REPORT,
        ST_FLUSH_START,
        ST_FINISH
    } state_t;

endpackage

FILE: rtl/maze_grid_to_adjacency.sv
`timescale 1ns / 1ps
// Top level of the maze grid to adjacency block: control FSM and cell chain.
// Depends on mga_pkg and mga_cell.

// Maze text enters one byte per request. A newline shifts the rows when no
// earlier row is held; otherwise the row of cells rotates one column per cycle,
// unless stalled, past the report point at cell 0, and the last result is
// released in the closing ST_FINISH state. The end-of-input request runs up to
// two row reports, and returns all state to reset. Any cycle in which a result
// is found while an earlier result is still held and the output register is
// full and not taken stalls the rotation. The block takes no new request while
// a row report is running.
module maze_grid_to_adjacency (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  mga_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output mga_pkg::out_t m_data
);
    import mga_pkg::*;

    state_t            state_reg, state_next;
    logic [COL_W-1:0]  col_reg;
    logic [IDX_W-1:0]  k_reg;
    node_id_t          next_id_reg;
    logic [1:0]        rows_reg;
    logic              sat_reg;
    logic              eoi_reg;
    logic              flush_reg;
    out_t              hold_reg;
    logic              hold_valid_reg;
    out_t              out_reg;
    out_t              out_next;
    logic              m_valid_reg;

    col_data_t         cell_q [MAX_ROW_WIDTH];
    logic [MAX_ROW_WIDTH-1:0] wr_en;
    cell_ctrl_t        ctrl;

    logic     in_acc;
    logic     is_open;
    logic     is_wall;
    logic     is_nl;
    logic     out_free;
    logic     cell_hit;
    logic     last_col;
    logic     step_ok;
    logic     fin_ok;
    out_t     new_res;
    cell_op_t op;
    logic     load_hold;
    logic     push;
    logic     push_last;
    logic     hold_drop;

    assign s_ready  = aresetn && (state_reg == ST_IDLE);
    assign in_acc   = s_valid && s_ready;
    assign is_open  = (s_data.character == CH_OPEN);
    assign is_wall  = (s_data.character == CH_WALL);
    assign is_nl    = (s_data.character == CH_NEWLINE);
    assign out_free = !m_valid_reg || m_ready;
    assign cell_hit = (cell_q[0].middle != ID_NONE);
    assign last_col = (k_reg == IDX_W'(MAX_ROW_WIDTH - 1));
    assign step_ok  = !cell_hit || !hold_valid_reg || out_free;
    assign fin_ok   = !hold_valid_reg || out_free;

    // After k rotations cell 0 holds column k, cell 1 column k+1, the far end column k-1
    always_comb begin
        new_res.node_id  = cell_q[0].middle;
        new_res.north_id = cell_q[0].above;
        new_res.east_id  = last_col ? ID_NONE : cell_q[1].middle;
        new_res.south_id = cell_q[0].below;
        new_res.west_id  = (k_reg == '0) ? ID_NONE : cell_q[MAX_ROW_WIDTH-1].middle;
        new_res.last     = 1'b0;
        new_res.overflow = sat_reg;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_data.end_of_input) begin
                        if (col_reg != '0 && rows_reg != 2'd0) begin
                            state_next = ST_REPORT;
                        end else begin
                            state_next = ST_FLUSH_START;
                        end
                    end else if (is_nl && rows_reg != 2'd0) begin
                        state_next = ST_REPORT;
                    end
                end
            end
            ST_REPORT: begin
                if (step_ok && last_col) begin
                    if (!flush_reg && eoi_reg) begin
                        state_next = ST_FLUSH_START;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FLUSH_START: begin
                state_next = (rows_reg != 2'd0) ? ST_REPORT : ST_FINISH;
            end
            ST_FINISH: begin
                if (fin_ok) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the FSM
    always_comb begin
        op        = CELL_IDLE;
        load_hold = 1'b0;
        push      = 1'b0;
        push_last = 1'b0;
        hold_drop = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_data.end_of_input) begin
                        if (col_reg != '0 && rows_reg == 2'd0) begin
                            op = CELL_SHIFT;
                        end
                    end else if (is_nl) begin
                        if (rows_reg == 2'd0) begin
                            op = CELL_SHIFT;
                        end
                    end else if ((is_open || is_wall) &&
                                 col_reg < COL_W'(MAX_ROW_WIDTH)) begin
                        op = CELL_WRITE;
                    end
                end
            end
            ST_REPORT: begin
                if (step_ok) begin
                    op = (last_col && !flush_reg) ? CELL_ROT_SHIFT : CELL_ROTATE;
                    if (cell_hit) begin
                        load_hold = 1'b1;
                        push      = hold_valid_reg;
                    end
                end
            end
            ST_FLUSH_START: begin
                if (rows_reg != 2'd0) begin
                    op = CELL_CLR_BELOW;
                end
            end
            ST_FINISH: begin
                if (fin_ok) begin
                    push      = hold_valid_reg;
                    push_last = 1'b1;
                    hold_drop = 1'b1;
                    if (eoi_reg) begin
                        op = CELL_CLEAR;
                    end
                end
            end
            default: begin
                op = CELL_IDLE;
            end
        endcase
    end

    assign ctrl.op      = op;
    assign ctrl.wr_data = is_open ? next_id_reg : ID_NONE;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ROW_WIDTH; gi++) begin : g_cell
            assign wr_en[gi] = (col_reg == COL_W'(gi));
            mga_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (ctrl),
                .wr_en   (wr_en[gi]),
                .nbr_in  (cell_q[(gi + 1) % MAX_ROW_WIDTH]),
                .col_out (cell_q[gi])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            col_reg        <= '0;
            k_reg          <= '0;
            next_id_reg    <= ID_FIRST;
            rows_reg       <= 2'd0;
            sat_reg        <= 1'b0;
            eoi_reg        <= 1'b0;
            flush_reg      <= 1'b0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (in_acc) begin
                eoi_reg   <= s_data.end_of_input;
                flush_reg <= 1'b0;
            end
            if (state_reg == ST_FLUSH_START) begin
                flush_reg <= 1'b1;
            end

            if (state_reg == ST_REPORT && step_ok) begin
                k_reg <= last_col ? '0 : k_reg + IDX_W'(1);
            end

            case (op)
                CELL_WRITE: begin
                    col_reg <= col_reg + COL_W'(1);
                    if (is_open) begin
                        if (next_id_reg == ID_MAX) begin
                            sat_reg <= 1'b1;
                        end else begin
                            next_id_reg <= next_id_reg + ID_W'(1);
                        end
                    end
                end
                CELL_SHIFT, CELL_ROT_SHIFT: begin
                    col_reg  <= '0;
                    rows_reg <= (rows_reg == 2'd2) ? 2'd2 : rows_reg + 2'd1;
                end
                CELL_CLEAR: begin
                    col_reg     <= '0;
                    rows_reg    <= 2'd0;
                    next_id_reg <= ID_FIRST;
                    sat_reg     <= 1'b0;
                end
                default: begin
                end
            endcase

            if (load_hold) begin
                hold_valid_reg <= 1'b1;
            end else if (hold_drop) begin
                hold_valid_reg <= 1'b0;
            end

            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        out_next      = hold_reg;
        out_next.last = push_last;
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (load_hold) begin
            hold_reg <= new_res;
        end
        if (push) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_idle_no_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !hold_valid_reg)
        else $error("held result left behind at idle");

    a_out_node: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_reg.node_id != ID_NONE))
        else $error("result with zero node id");

    a_rows_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rows_reg != 2'd3)
        else $error("rows held out of range");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= COL_W'(MAX_ROW_WIDTH))
        else $error("column position out of range");

    a_report_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_REPORT && state_next == ST_REPORT) |-> (k_reg == '0))
        else $error("row report entered off column zero");
`endif

endmodule

FILE: rtl/mga_cell.sv
`timescale 1ns / 1ps
// One column cell of the row buffer chain: above, middle and below IDs.
// Depends on mga_pkg for the column struct and cell operations.
module mga_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  mga_pkg::cell_ctrl_t ctrl,
    input  logic               wr_en,
    input  mga_pkg::col_data_t nbr_in,
    output mga_pkg::col_data_t col_out
);
    import mga_pkg::*;

    col_data_t col_reg;
    col_data_t col_next;

    always_comb begin
        col_next = col_reg;
        case (ctrl.op)
            CELL_IDLE: begin
                col_next = col_reg;
            end
            CELL_WRITE: begin
                if (wr_en) begin
                    col_next.below = ctrl.wr_data;
                end
            end
            CELL_ROTATE: begin
                col_next = nbr_in;
            end
            CELL_SHIFT: begin
                col_next.above  = col_reg.middle;
                col_next.middle = col_reg.below;
                col_next.below  = ID_NONE;
            end
            CELL_ROT_SHIFT: begin
                // take the neighbor's column and advance the rows in one step
                col_next.above  = nbr_in.middle;
                col_next.middle = nbr_in.below;
                col_next.below  = ID_NONE;
            end
            CELL_CLR_BELOW: begin
                col_next.below = ID_NONE;
            end
            CELL_CLEAR: begin
                col_next = '0;
            end
            default: begin
                col_next = col_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else begin
            col_reg <= col_next;
        end
    end

    assign col_out = col_reg;

endmodule
